>>> design/qsdm_pkg.sv
// Shared types, codes and constants of the quadrature speed and distance meter.
package qsdm_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int PROD_W      = COUNT_WIDTH + 32;
	localparam int PADDR_W     = 3;

	localparam logic [63:0] HOLD_LIMIT = 64'd100000;

	localparam logic [31:0] SPEED_SCALE_RST = 32'd6553600;
	localparam logic [31:0] DEG_PER_TICK_RST = 32'd65536;

	localparam logic [1:0] FUNC_PIN   = 2'd0;
	localparam logic [1:0] FUNC_SPEED = 2'd1;
	localparam logic [1:0] FUNC_DIST  = 2'd2;

	localparam logic KIND_SPEED = 1'b0;
	localparam logic KIND_DIST  = 1'b1;

	localparam logic REG_SPEED_SCALE  = 1'b0;
	localparam logic REG_DEG_PER_TICK = 1'b1;

	typedef struct packed {
		logic [1:0] func;
		logic       level_a;
		logic       level_b;
	} item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               kind;
		logic               speed_held;
	} result_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] mag;
		logic                   neg;
		logic                   held;
		logic                   kind;
	} stage_t;

endpackage

>>> design/quadrature_speed_distance_meter_top.sv
// Top level of the quadrature speed and distance meter.
// A speed-sample or distance-read word is registered in the front stage, then in the result register.
// One input word is taken per cycle while the result side does not stall; pin-change words give no result.
// The rate is set by the stage register before the single 32 by 32 multiplier.
// Reset clears the tick count, snapshot, accumulator, previous speed and valid flags at once,
// and returns both scale registers to their reset values.
module quadrature_speed_distance_meter_top import qsdm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  item_t              item,
	output logic               res_valid,
	input  logic               res_ready,
	output result_t            res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// Scale factors from the register file, both in Q16.16.
	logic [31:0] speed_scale;
	logic [31:0] degrees_per_tick;

	// The front stage hands a registered magnitude, its sign and the hold decision
	// to the scaling stage; adv says the scaling stage can take it this cycle.
	logic   valid_s1;
	stage_t stage_s1;
	logic   adv;

	qsdm_cfg_regs u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.speed_scale      (speed_scale),
		.degrees_per_tick (degrees_per_tick)
	);

	// The counters are updated at the moment a word is accepted, so each word
	// sees the state left by the one before it, even while results are waiting.
	qsdm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.adv        (adv),
		.valid_s1   (valid_s1),
		.stage_s1   (stage_s1)
	);

	// The previous speed lives in the scaling stage, where results leave in order,
	// so a held sample always picks up the speed of the last sample that was not held.
	qsdm_scale u_scale (
		.clk              (clk),
		.arst_n           (arst_n),
		.valid_s1         (valid_s1),
		.stage_s1         (stage_s1),
		.speed_scale      (speed_scale),
		.degrees_per_tick (degrees_per_tick),
		.adv              (adv),
		.res_valid        (res_valid),
		.res              (res),
		.res_ready        (res_ready)
	);

endmodule

>>> design/qsdm_cfg_regs.sv
// APB register file holding the two Q16.16 scale factors.
module qsdm_cfg_regs import qsdm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [31:0]        speed_scale,
	output logic [31:0]        degrees_per_tick
);

	logic [31:0] speed_scale_q;
	logic [31:0] deg_per_tick_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_scale_q  <= SPEED_SCALE_RST;
			deg_per_tick_q <= DEG_PER_TICK_RST;
		end else if (wr_en) begin
			if (paddr[2] == REG_SPEED_SCALE) begin
				speed_scale_q <= pwdata;
			end else begin
				deg_per_tick_q <= pwdata;
			end
		end
	end

	assign prdata = (paddr[2] == REG_SPEED_SCALE) ? speed_scale_q : deg_per_tick_q;
	assign speed_scale      = speed_scale_q;
	assign degrees_per_tick = deg_per_tick_q;

endmodule

>>> design/qsdm_front.sv
// Tick counter, snapshot and travel accumulator; registers the magnitude to be scaled.
module qsdm_front import qsdm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   item_valid,
	input  item_t  item,
	output logic   item_ready,
	input  logic   adv,
	output logic   valid_s1,
	output stage_t stage_s1
);

	logic [COUNT_WIDTH-1:0] tick_q;
	logic [COUNT_WIDTH-1:0] snap_q;
	logic [COUNT_WIDTH-1:0] acc_q;
	logic                   valid_q;
	stage_t                 stage_q;
	logic                   accept;
	logic [COUNT_WIDTH-1:0] diff;
	logic [COUNT_WIDTH-1:0] sel;
	logic [COUNT_WIDTH-1:0] mag;
	logic                   neg;
	logic                   load;

	assign item_ready = !valid_q || adv;
	assign accept     = item_valid && item_ready;
	assign load       = accept && (item.func == FUNC_SPEED || item.func == FUNC_DIST);

	assign diff = tick_q - snap_q;
	assign sel  = (item.func == FUNC_SPEED) ? diff : acc_q;
	assign neg  = sel[COUNT_WIDTH-1];
	assign mag  = neg ? (~sel + COUNT_WIDTH'(1)) : sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			snap_q  <= '0;
			acc_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (accept) begin
				case (item.func)
					FUNC_PIN: begin
						if (item.level_a == item.level_b) begin
							tick_q <= tick_q + COUNT_WIDTH'(1);
						end else begin
							tick_q <= tick_q - COUNT_WIDTH'(1);
						end
					end
					FUNC_SPEED: begin
						snap_q <= tick_q;
						acc_q  <= acc_q + diff;
					end
					FUNC_DIST: begin
						acc_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (adv) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			stage_q.mag  <= mag;
			stage_q.neg  <= neg;
			stage_q.kind <= (item.func == FUNC_SPEED) ? KIND_SPEED : KIND_DIST;
			stage_q.held <= (item.func == FUNC_SPEED) && (64'(mag) >= HOLD_LIMIT);
		end
	end

	assign valid_s1 = valid_q;
	assign stage_s1 = stage_q;

endmodule

>>> design/qsdm_scale.sv
// Q16.16 multiply, truncation and saturation, held-speed selection and result register.
module qsdm_scale import qsdm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  stage_t      stage_s1,
	input  logic [31:0] speed_scale,
	input  logic [31:0] degrees_per_tick,
	output logic        adv,
	output logic        res_valid,
	output result_t     res,
	input  logic        res_ready
);

	logic [31:0]        scale;
	logic [PROD_W-1:0]  prod;
	logic               sat;
	logic [31:0]        shifted;
	logic               big;
	logic signed [31:0] scaled;
	logic signed [31:0] value;
	logic signed [31:0] prev_q;
	logic               res_valid_q;
	result_t            res_q;

	assign adv = !res_valid_q || res_ready;

	assign scale   = (stage_s1.kind == KIND_SPEED) ? speed_scale : degrees_per_tick;
	assign prod    = PROD_W'(stage_s1.mag) * PROD_W'(scale);
	assign sat     = |(prod >> 48);
	assign shifted = prod[47:16];
	assign big     = sat || shifted[31];

	always_comb begin
		if (stage_s1.neg) begin
			scaled = big ? 32'sh8000_0000 : -$signed(shifted);
		end else begin
			scaled = big ? 32'sh7fff_ffff : $signed(shifted);
		end
		value = stage_s1.held ? prev_q : scaled;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			prev_q      <= '0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
			if (valid_s1 && stage_s1.kind == KIND_SPEED && !stage_s1.held) begin
				prev_q <= scaled;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_q.value      <= value;
			res_q.kind       <= stage_s1.kind;
			res_q.speed_held <= stage_s1.held;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> design/qsdm_checker.sv
// Port-level checker for the quadrature speed and distance meter, with its bind.
module qsdm_checker import qsdm_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    res_valid,
	input logic    res_ready,
	input result_t res,
	input logic    pready
);

	logic signed [31:0] last_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_speed_q <= '0;
		end else if (res_valid && res_ready && res.kind == KIND_SPEED && !res.speed_held) begin
			last_speed_q <= res.value;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed before it was taken");

	a_dist_not_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_DIST |-> !res.speed_held)
		else $error("distance word flagged as held speed");

	a_held_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_SPEED && res.speed_held |-> res.value == last_speed_q)
		else $error("held speed differs from the last fresh speed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind quadrature_speed_distance_meter_top qsdm_checker u_qsdm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res),
	.pready    (pready)
);

>>> tb/sv/meter_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the speed and distance readings of the meter.
package meter_scoreboard_pkg;

	import qsdm_pkg::*;

	// The fourth event code carries no meaning and must leave the meter untouched.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	class meter_scoreboard;

		logic [COUNT_WIDTH-1:0] tick_total;
		logic [COUNT_WIDTH-1:0] snapshot;
		logic [COUNT_WIDTH-1:0] travel;
		logic signed [31:0]     last_speed;
		logic [31:0]            speed_scale;
		logic [31:0]            deg_per_tick;
		result_t                expected_readings[$];
		int                     mismatch_count;

		function new();
			tick_total     = '0;
			snapshot       = '0;
			travel         = '0;
			last_speed     = '0;
			speed_scale    = SPEED_SCALE_RST;
			deg_per_tick   = DEG_PER_TICK_RST;
			mismatch_count = 0;
		endfunction

		function void set_register(logic idx, logic [31:0] v);
			if (idx == REG_SPEED_SCALE) begin
				speed_scale = v;
			end else begin
				deg_per_tick = v;
			end
		endfunction

		function logic [COUNT_WIDTH-1:0] magnitude(logic [COUNT_WIDTH-1:0] v);
			return v[COUNT_WIDTH-1] ? -v : v;
		endfunction

		// Signed count times a Q16.16 scale, truncated towards zero and clamped to 32 bits.
		function logic signed [31:0] scaled(logic [COUNT_WIDTH-1:0] v, logic [31:0] scale);
			logic [PROD_W-1:0] shifted;
			shifted = (PROD_W'(magnitude(v)) * PROD_W'(scale)) >> 16;
			if (v[COUNT_WIDTH-1]) begin
				if (shifted >= (PROD_W'(1) << 31)) begin
					return 32'sh8000_0000;
				end
				return -shifted[31:0];
			end
			if (shifted > PROD_W'(32'h7FFF_FFFF)) begin
				return 32'sh7FFF_FFFF;
			end
			return shifted[31:0];
		endfunction

		function void note_word(item_t w);
			result_t                r;
			logic [COUNT_WIDTH-1:0] diff;
			case (w.func)
				FUNC_PIN: begin
					if (w.level_a == w.level_b) begin
						tick_total = tick_total + 1'b1;
					end else begin
						tick_total = tick_total - 1'b1;
					end
				end
				FUNC_SPEED: begin
					diff     = tick_total - snapshot;
					snapshot = tick_total;
					travel   = travel + diff;
					r.kind   = KIND_SPEED;
					if (magnitude(diff) >= HOLD_LIMIT) begin
						r.value      = last_speed;
						r.speed_held = 1'b1;
					end else begin
						last_speed   = scaled(diff, speed_scale);
						r.value      = last_speed;
						r.speed_held = 1'b0;
					end
					expected_readings.push_back(r);
				end
				FUNC_DIST: begin
					r.value      = scaled(travel, deg_per_tick);
					r.kind       = KIND_DIST;
					r.speed_held = 1'b0;
					travel       = '0;
					expected_readings.push_back(r);
				end
				default: begin
				end
			endcase
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $time, what);
			mismatch_count++;
		endtask

		task check_word(result_t got);
			result_t want;
			if (expected_readings.size() == 0) begin
				report($sformatf("unexpected result value=%0d kind=%0b held=%0b",
					got.value, got.kind, got.speed_held));
				return;
			end
			want = expected_readings.pop_front();
			if (got.value !== want.value || got.kind !== want.kind ||
				got.speed_held !== want.speed_held) begin
				report($sformatf("value %0d/%0d kind %0b/%0b held %0b/%0b (got/expected)",
					got.value, want.value, got.kind, want.kind, got.speed_held,
					want.speed_held));
			end
		endtask

		task flush_missing();
			while (expected_readings.size() != 0) begin
				report($sformatf("result never arrived, expected value=%0d kind=%0b",
					expected_readings[0].value, expected_readings[0].kind));
				void'(expected_readings.pop_front());
			end
		endtask

		function int pending();
			return expected_readings.size();
		endfunction

	endclass

endpackage

>>> tb/sv/tb_top.sv
// Testbench top: drives events and register writes into the meter and checks every reading.
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import qsdm_pkg::*;
	import meter_scoreboard_pkg::*;

	// Cycles allowed after the last reading for a trailing pin-change word to clear the pipe.
	localparam int DRAIN_CYCLES = 4;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	item_t              item;
	logic               res_valid;
	logic               res_ready;
	result_t            res;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int send_idle_pct;
	int recv_stall_pct;

	meter_scoreboard sb = new();

	quadrature_speed_distance_meter_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #5 clk = ~clk;

	// The result side is released or held back afresh on every falling edge.
	always @(negedge clk) begin
		res_ready = ($urandom_range(99) >= recv_stall_pct);
	end

	// Both handshakes are observed at the rising edge. An accepted word is fed to the
	// predictor before any reading is checked, so the order would hold even for a reading in the same cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				sb.note_word(item);
			end
			if (res_valid && res_ready) begin
				sb.check_word(res);
			end
		end
	end

	function item_t word_of(logic [1:0] f, logic a, logic b);
		item_t w;
		w.func    = f;
		w.level_a = a;
		w.level_b = b;
		return w;
	endfunction

	// A pin change counts up when the two channels agree and down when they differ;
	// the level of channel A itself is random so that both levels are exercised.
	function item_t pin_change(logic up);
		logic a;
		a = 1'($urandom_range(1));
		return word_of(FUNC_PIN, a, up ? a : ~a);
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	// Valid stays high between back-to-back words and only drops when the sender idles.
	task send_word(item_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		item       = w;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	// Speed samples, distance reads and unused codes carry random, ignored levels.
	task send_cmd(logic [1:0] f);
		send_word(word_of(f, 1'($urandom_range(1)), 1'($urandom_range(1))));
	endtask

	task walk_ticks(int n, logic up);
		repeat (n) send_word(pin_change(up));
	endtask

	// Waits until every predicted reading has come back, then lets the pipe run dry.
	task settle();
		int waited;
		waited     = 0;
		item_valid = 1'b0;
		while (sb.pending() != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task read_register(logic idx, output logic [31:0] data);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = PADDR_W'(idx) << 2;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Setup cycle, then access cycle; the register is read straight back afterwards.
	task write_register(logic idx, logic [31:0] v);
		logic [31:0] back;
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = PADDR_W'(idx) << 2;
		pwdata  = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, v);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		read_register(idx, back);
		if (back !== v) begin
			sb.report($sformatf("register %0d read back %h, written %h", idx, back, v));
		end
	endtask

	// The first three settings pin the scales at their extremes; later ones are random,
	// some across the whole range and some small enough that products rarely clamp.
	task apply_setting(int k);
		settle();
		case (k)
			0: begin
				write_register(REG_SPEED_SCALE, 32'hFFFF_FFFF);
				write_register(REG_DEG_PER_TICK, 32'h0000_0000);
			end
			1: begin
				write_register(REG_SPEED_SCALE, 32'h0000_0000);
				write_register(REG_DEG_PER_TICK, 32'hFFFF_FFFF);
			end
			2: begin
				write_register(REG_SPEED_SCALE, 32'h0000_0001);
				write_register(REG_DEG_PER_TICK, 32'h0000_0001);
			end
			default: begin
				write_register(REG_SPEED_SCALE,
					$urandom_range(1) ? $urandom() : $urandom_range(32'h00FF_FFFF));
				write_register(REG_DEG_PER_TICK,
					$urandom_range(1) ? $urandom() : $urandom_range(32'h00FF_FFFF));
			end
		endcase
	endtask

	// Mostly pin changes, with the drift direction redrawn at every speed sample so
	// that readings swing between forward, reverse and standstill.
	task run_segment(int count);
		int r;
		int bias;
		bias = 50;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 72) begin
				send_word(pin_change($urandom_range(99) < bias));
			end else if (r < 86) begin
				send_cmd(FUNC_SPEED);
				bias = $urandom_range(100);
			end else if (r < 95) begin
				send_cmd(FUNC_DIST);
			end else begin
				send_cmd(FUNC_UNUSED);
			end
		end
	endtask

	initial begin
		logic [31:0] reg_value;

		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		res_ready      = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		send_idle_pct  = 27;
		recv_stall_pct = 84;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Both scales must come out of reset at 100.0 and 1.0.
		read_register(REG_SPEED_SCALE, reg_value);
		if (reg_value !== SPEED_SCALE_RST) begin
			sb.report($sformatf("speed scale after reset %h", reg_value));
		end
		read_register(REG_DEG_PER_TICK, reg_value);
		if (reg_value !== DEG_PER_TICK_RST) begin
			sb.report($sformatf("degrees per tick after reset %h", reg_value));
		end

		// Directed words at the reset scales. A sample and a read at standstill give zero.
		send_cmd(FUNC_SPEED);
		send_cmd(FUNC_DIST);
		// Every combination of the two channels, ending three ticks forward.
		send_word(word_of(FUNC_PIN, 1'b0, 1'b0));
		send_word(word_of(FUNC_PIN, 1'b1, 1'b1));
		send_word(word_of(FUNC_PIN, 1'b0, 1'b1));
		send_word(word_of(FUNC_PIN, 1'b1, 1'b0));
		send_word(word_of(FUNC_PIN, 1'b1, 1'b1));
		send_word(word_of(FUNC_PIN, 1'b0, 1'b0));
		send_word(word_of(FUNC_PIN, 1'b1, 1'b1));
		// The unused code must neither count nor answer.
		send_word(word_of(FUNC_UNUSED, 1'b1, 1'b1));
		send_word(word_of(FUNC_UNUSED, 1'b0, 1'b0));
		send_cmd(FUNC_SPEED);
		// Five ticks backwards gives a negative speed, then a net distance of minus two
		// degrees, and a second read finds the accumulator cleared.
		walk_ticks(5, 1'b0);
		send_cmd(FUNC_SPEED);
		send_cmd(FUNC_DIST);
		send_cmd(FUNC_DIST);

		// Random traffic in three idling regimes, each with three scale settings.
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct  = 27;
					recv_stall_pct = 84;
				end
				1: begin
					send_idle_pct  = 84;
					recv_stall_pct = 27;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int s = 0; s < 3; s++) begin
				apply_setting(p * 3 + s);
				run_segment(210);
			end
		end

		// Half a degree per tick: an odd distance loses its half degree towards zero,
		// forwards as well as backwards.
		settle();
		write_register(REG_SPEED_SCALE, 32'h0003_0000);
		write_register(REG_DEG_PER_TICK, 32'h0000_8000);
		send_cmd(FUNC_SPEED);
		send_cmd(FUNC_DIST);
		walk_ticks(7, 1'b1);
		send_cmd(FUNC_SPEED);
		send_cmd(FUNC_DIST);
		walk_ticks(5, 1'b0);
		send_cmd(FUNC_SPEED);
		send_cmd(FUNC_DIST);

		settle();
		sb.flush_missing();
		if (sb.mismatch_count == 0) begin
			$display("[quadrature_speed_distance_meter_top] OK");
		end else begin
			$display("[quadrature_speed_distance_meter_top] ERROR");
		end
		$finish;
	end

	// The whole run needs well under a million nanoseconds; this only catches a hang.
	initial begin
		#15_000_000;
		$display("[quadrature_speed_distance_meter_top] ERROR");
		$finish;
	end

endmodule
